@@ rtl/lkg_pkg.sv @@
// shared types, constants and cosine coefficients for the lissajous knot generator
package lkg_pkg;

  localparam int PHASE_BITS_DEF = 16;
  localparam int OUT_BITS_DEF   = 16;
  localparam int IN_BITS        = 16;
  localparam int REG_BITS       = 16;
  localparam int ANG_FRAC       = 23;
  localparam int Q_BITS         = 31;
  localparam int HORNER_STEPS   = 6;
  localparam int LATENCY        = 4 + HORNER_STEPS;

  localparam logic [REG_BITS-1:0] RATIO_X_RST  = 16'd768;
  localparam logic [REG_BITS-1:0] RATIO_Y_RST  = 16'd512;
  localparam logic [REG_BITS-1:0] RATIO_Z_RST  = 16'd1792;
  localparam logic [REG_BITS-1:0] OFFSET_X_RST = 16'd7301;
  localparam logic [REG_BITS-1:0] OFFSET_Y_RST = 16'd2086;

  typedef enum logic [2:0] {
    REG_RATIO_X  = 3'd0,
    REG_RATIO_Y  = 3'd1,
    REG_RATIO_Z  = 3'd2,
    REG_OFFSET_X = 3'd3,
    REG_OFFSET_Y = 3'd4
  } reg_index_t;

  // folded angle handed from the angle stage to the cosine stage
  typedef struct packed {
    logic [1:0]        quad;
    logic [Q_BITS-1:0] u;
  } angle_t;

  localparam logic [Q_BITS-1:0] COS_COEF [HORNER_STEPS+1] = '{
    31'd1073741824, 31'd1324675879, 31'd272375560, 31'd22401992,
    31'd987048, 31'd27061, 31'd506
  };

endpackage

@@ rtl/lissajous_knot_3d_generator.sv @@
// top level: register file, three axis lanes and valid pipeline
// throughput: one transaction per cycle unless a waiting coord transaction holds
//   the pipeline; depth set by the two angle stages, the squaring stage, six horner
//   stages and the rounding stage of each lane
// reset: synchronous, clears the valid pipeline and loads the default ratios
//   and offsets; cfg writes are always accepted
module lissajous_knot_3d_generator #(
  parameter int PHASE_BITS = lkg_pkg::PHASE_BITS_DEF,
  parameter int OUT_BITS   = lkg_pkg::OUT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [2:0]                         cfg_index,
  input  logic [lkg_pkg::REG_BITS-1:0]       cfg_data,
  input  logic                               phase_valid,
  output logic                               phase_ready,
  input  logic signed [lkg_pkg::IN_BITS-1:0] phase_in,
  output logic                               coord_valid,
  input  logic                               coord_ready,
  output logic signed [OUT_BITS-1:0]         coord_x,
  output logic signed [OUT_BITS-1:0]         coord_y,
  output logic signed [OUT_BITS-1:0]         coord_z
);

  localparam int LAT = lkg_pkg::LATENCY;

  logic [lkg_pkg::REG_BITS-1:0] ratio_x;
  logic [lkg_pkg::REG_BITS-1:0] ratio_y;
  logic [lkg_pkg::REG_BITS-1:0] ratio_z;
  logic [lkg_pkg::REG_BITS-1:0] offset_x;
  logic [lkg_pkg::REG_BITS-1:0] offset_y;
  logic [LAT-1:0]               vld;
  logic                         en;
  lkg_pkg::angle_t              ang_x;
  lkg_pkg::angle_t              ang_y;
  lkg_pkg::angle_t              ang_z;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ratio_x  <= lkg_pkg::RATIO_X_RST;
      ratio_y  <= lkg_pkg::RATIO_Y_RST;
      ratio_z  <= lkg_pkg::RATIO_Z_RST;
      offset_x <= lkg_pkg::OFFSET_X_RST;
      offset_y <= lkg_pkg::OFFSET_Y_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lkg_pkg::REG_RATIO_X:  ratio_x  <= cfg_data;
        lkg_pkg::REG_RATIO_Y:  ratio_y  <= cfg_data;
        lkg_pkg::REG_RATIO_Z:  ratio_z  <= cfg_data;
        lkg_pkg::REG_OFFSET_X: offset_x <= cfg_data;
        lkg_pkg::REG_OFFSET_Y: offset_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // whole pipeline holds while the output transaction waits
  assign en          = !coord_valid || coord_ready;
  assign phase_ready = en;
  assign coord_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], phase_valid};
    end
  end

  lkg_angle #(.PHASE_BITS(PHASE_BITS)) u_angle_x (
    .clk(clk), .en(en), .phase(phase_in), .ratio(ratio_x), .offset(offset_x), .angle(ang_x)
  );

  lkg_angle #(.PHASE_BITS(PHASE_BITS)) u_angle_y (
    .clk(clk), .en(en), .phase(phase_in), .ratio(ratio_y), .offset(offset_y), .angle(ang_y)
  );

  lkg_angle #(.PHASE_BITS(PHASE_BITS)) u_angle_z (
    .clk(clk), .en(en), .phase(phase_in), .ratio(ratio_z), .offset('0), .angle(ang_z)
  );

  lkg_cos #(.OUT_BITS(OUT_BITS)) u_cos_x (
    .clk(clk), .en(en), .angle(ang_x), .coord(coord_x)
  );

  lkg_cos #(.OUT_BITS(OUT_BITS)) u_cos_y (
    .clk(clk), .en(en), .angle(ang_y), .coord(coord_y)
  );

  lkg_cos #(.OUT_BITS(OUT_BITS)) u_cos_z (
    .clk(clk), .en(en), .angle(ang_z), .coord(coord_z)
  );

endmodule

@@ rtl/lkg_angle.sv @@
// phase scaling, offset, turn wrap and quadrant fold for one axis
module lkg_angle #(
  parameter int PHASE_BITS = lkg_pkg::PHASE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [lkg_pkg::IN_BITS-1:0] phase,
  input  logic [lkg_pkg::REG_BITS-1:0]       ratio,
  input  logic [lkg_pkg::REG_BITS-1:0]       offset,
  output lkg_pkg::angle_t                    angle
);

  localparam int FRAC = lkg_pkg::ANG_FRAC;
  localparam logic [PHASE_BITS-2:0] QUARTER = (PHASE_BITS-1)'(1) << (PHASE_BITS-2);

  logic signed [lkg_pkg::REG_BITS:0]                  ratio_s;
  logic signed [lkg_pkg::IN_BITS+lkg_pkg::REG_BITS:0] prod;
  logic [FRAC-1:0]       t_next;
  logic [FRAC-1:0]       t;
  logic [PHASE_BITS-1:0] p;
  logic [1:0]            quad;
  logic [PHASE_BITS-3:0] frac;
  logic [PHASE_BITS-2:0] fold;
  lkg_pkg::angle_t       angle_next;

  assign ratio_s = {1'b0, ratio};
  assign prod    = phase * ratio_s;
  assign t_next  = prod[FRAC-1:0] + {offset, 7'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      t <= t_next;
    end
  end

  generate
    if (PHASE_BITS <= FRAC) begin : g_trunc
      assign p = t[FRAC-1 -: PHASE_BITS];
    end else begin : g_extend
      assign p = {t, {(PHASE_BITS-FRAC){1'b0}}};
    end
  endgenerate

  assign quad = p[PHASE_BITS-1 -: 2];
  assign frac = p[PHASE_BITS-3:0];
  assign fold = quad[0] ? (QUARTER - {1'b0, frac}) : {1'b0, frac};

  assign angle_next.quad = quad;
  assign angle_next.u    = {fold, {(32-PHASE_BITS){1'b0}}};

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= angle_next;
    end
  end

endmodule

@@ rtl/lkg_cos.sv @@
// pipelined quarter-wave polynomial cosine with rounding, saturation and sign
module lkg_cos #(
  parameter int OUT_BITS = lkg_pkg::OUT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       en,
  input  lkg_pkg::angle_t            angle,
  output logic signed [OUT_BITS-1:0] coord
);

  localparam int QB    = lkg_pkg::Q_BITS;
  localparam int STEPS = lkg_pkg::HORNER_STEPS;
  localparam logic [31:0] RND = 32'd1 << (30 - OUT_BITS);
  localparam logic [31:0] LIM = (32'd1 << (OUT_BITS - 1)) - 32'd1;

  logic [2*QB-1:0] sq;
  logic [QB-1:0]   s_st [STEPS+1];
  logic [1:0]      q_st [STEPS+1];
  logic [QB-1:0]   r_st [STEPS+1];

  logic [31:0]         sum;
  logic [31:0]         mr;
  logic [OUT_BITS-1:0] mag;
  logic                neg;

  assign sq = angle.u * angle.u;

  always_ff @(posedge clk) begin
    if (en) begin
      s_st[0] <= sq[QB+29:30];
      q_st[0] <= angle.quad;
    end
  end

  assign r_st[0] = lkg_pkg::COS_COEF[STEPS];

  // one horner step per stage
  generate
    for (genvar j = 0; j < STEPS; j++) begin : g_step
      logic [2*QB-1:0] prod;
      logic [31:0]     prod_sh;
      logic [31:0]     coef;
      logic [QB-1:0]   r_next;

      assign prod    = r_st[j] * s_st[j];
      assign prod_sh = prod[61:30];
      assign coef    = {1'b0, lkg_pkg::COS_COEF[STEPS-1-j]};
      assign r_next  = (coef > prod_sh) ? QB'(coef - prod_sh) : '0;

      always_ff @(posedge clk) begin
        if (en) begin
          r_st[j+1] <= r_next;
          s_st[j+1] <= s_st[j];
          q_st[j+1] <= q_st[j];
        end
      end
    end
  endgenerate

  assign sum = {1'b0, r_st[STEPS]} + RND;
  assign mr  = sum >> (31 - OUT_BITS);
  assign mag = (mr > LIM) ? LIM[OUT_BITS-1:0] : mr[OUT_BITS-1:0];
  assign neg = (q_st[STEPS] == 2'd1) || (q_st[STEPS] == 2'd2);

  always_ff @(posedge clk) begin
    if (en) begin
      coord <= neg ? -mag : mag;
    end
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// testbench for the lissajous knot generator: predicts every point and checks all three coords
module tb_top;

  localparam int ANGLE_FRAC   = 23;
  localparam int PH_BITS      = 16;
  localparam int CO_BITS      = 16;
  localparam int OFFS_SHIFT   = ANGLE_FRAC - 16;
  localparam int MAX_WAIT     = 19;
  localparam int TAIL_CYCLES  = 24;
  localparam int HOLD_CYCLES  = 300;
  localparam int SWEEP_SETS   = 13;
  localparam int SWEEP_ITEMS  = 120;
  localparam int RUN_LIMIT_NS = 5_000_000;

  typedef struct packed {
    logic [CO_BITS-1:0] x;
    logic [CO_BITS-1:0] y;
    logic [CO_BITS-1:0] z;
  } point_t;

  logic                               clk = 1'b0;
  logic                               rst;
  logic                               cfg_valid;
  logic                               cfg_ready;
  logic [2:0]                         cfg_index;
  logic [lkg_pkg::REG_BITS-1:0]       cfg_data;
  logic                               phase_valid;
  logic                               phase_ready;
  logic signed [lkg_pkg::IN_BITS-1:0] phase_in;
  logic                               coord_valid;
  logic                               coord_ready;
  logic signed [CO_BITS-1:0]          coord_x;
  logic signed [CO_BITS-1:0]          coord_y;
  logic signed [CO_BITS-1:0]          coord_z;

  logic [15:0] knot_ratio_x, knot_ratio_y, knot_ratio_z;
  logic [15:0] knot_offset_x, knot_offset_y;

  point_t expected_points[$];
  bit     sender_idles;
  bit     receiver_idles;
  int     hold_cycles;
  int     mismatch_count = 0;
  int     n_sent = 0;
  int     n_writes = 0;
  int     n_checked = 0;

  lissajous_knot_3d_generator #(
    .PHASE_BITS(PH_BITS),
    .OUT_BITS(CO_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .phase_valid(phase_valid),
    .phase_ready(phase_ready),
    .phase_in(phase_in),
    .coord_valid(coord_valid),
    .coord_ready(coord_ready),
    .coord_x(coord_x),
    .coord_y(coord_y),
    .coord_z(coord_z)
  );

  always #4 clk = ~clk;

  function automatic logic [63:0] horner_coef(input int k);
    case (k)
      0: horner_coef = 64'd1073741824;
      1: horner_coef = 64'd1324675879;
      2: horner_coef = 64'd272375560;
      3: horner_coef = 64'd22401992;
      4: horner_coef = 64'd987048;
      5: horner_coef = 64'd27061;
      default: horner_coef = 64'd506;
    endcase
  endfunction

  // q30 cos(pi*u/2), truncating horner steps, clamped at zero
  function automatic logic [63:0] quarter_wave(input logic [63:0] u);
    logic [63:0] sq, acc, mul;
    sq = (u * u) >> 30;
    acc = horner_coef(6);
    for (int k = 5; k >= 0; k--) begin
      mul = (acc * sq) >> 30;
      acc = (horner_coef(k) > mul) ? horner_coef(k) - mul : 64'd0;
    end
    return acc;
  endfunction

  function automatic logic [CO_BITS-1:0] axis_cos(input logic [15:0] ph,
                                                  input logic [15:0] ratio,
                                                  input logic [15:0] offs);
    logic [63:0]        ang, mag, u;
    logic [PH_BITS-1:0] turn;
    logic [1:0]         quad;
    logic [PH_BITS-2:0] frac;
    ang = ({{48{ph[15]}}, ph} * {48'd0, ratio} + ({48'd0, offs} << OFFS_SHIFT))
          & ((64'd1 << ANGLE_FRAC) - 64'd1);
    turn = PH_BITS'(ang >> (ANGLE_FRAC - PH_BITS));
    quad = turn[PH_BITS-1 -: 2];
    frac = {1'b0, turn[PH_BITS-3:0]};
    if (quad[0]) frac = (PH_BITS-1)'((1 << (PH_BITS - 2)) - frac);
    u = 64'(frac) << (32 - PH_BITS);
    mag = quarter_wave(u);
    mag = (mag + (64'd1 << (30 - CO_BITS))) >> (31 - CO_BITS);
    if (mag > (64'd1 << (CO_BITS - 1)) - 64'd1) mag = (64'd1 << (CO_BITS - 1)) - 64'd1;
    // second and third quadrants are negative
    if (quad[0] ^ quad[1]) mag = 64'd0 - mag;
    return mag[CO_BITS-1:0];
  endfunction

  function automatic point_t predict_point(input logic [15:0] ph);
    point_t p;
    p.x = axis_cos(ph, knot_ratio_x, knot_offset_x);
    p.y = axis_cos(ph, knot_ratio_y, knot_offset_y);
    p.z = axis_cos(ph, knot_ratio_z, 16'd0);
    return p;
  endfunction

  function automatic logic [15:0] pick_reg_value();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(1, 16) << 8);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_phase();
    if ($urandom_range(0, 3) != 0) return 16'($urandom);
    // near a quarter-turn boundary
    return 16'(($urandom_range(0, 3) << 14) + $urandom_range(0, 8) - 4);
  endfunction

  task automatic send_phase(input logic [15:0] ph);
    int gap;
    gap = sender_idles ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      phase_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    phase_valid <= 1'b1;
    phase_in <= ph;
    @(posedge clk);
    while (!phase_ready) @(posedge clk);
    expected_points.push_back(predict_point(ph));
    n_sent++;
  endtask

  task automatic wait_points();
    phase_valid <= 1'b0;
    do @(posedge clk); while (expected_points.size() != 0);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    n_writes++;
    case (idx)
      lkg_pkg::REG_RATIO_X:  knot_ratio_x = val;
      lkg_pkg::REG_RATIO_Y:  knot_ratio_y = val;
      lkg_pkg::REG_RATIO_Z:  knot_ratio_z = val;
      lkg_pkg::REG_OFFSET_X: knot_offset_x = val;
      lkg_pkg::REG_OFFSET_Y: knot_offset_y = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_all(input logic [15:0] rx, input logic [15:0] ry, input logic [15:0] rz,
                           input logic [15:0] ox, input logic [15:0] oy);
    write_reg(lkg_pkg::REG_RATIO_X, rx);
    write_reg(lkg_pkg::REG_RATIO_Y, ry);
    write_reg(lkg_pkg::REG_RATIO_Z, rz);
    write_reg(lkg_pkg::REG_OFFSET_X, ox);
    write_reg(lkg_pkg::REG_OFFSET_Y, oy);
  endtask

  task automatic test_reset_defaults();
    logic [15:0] phases[10];
    phases = '{16'h0000, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF,
               16'h4000, 16'hC000, 16'h2000, 16'hA000, 16'h1234};
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    foreach (phases[i]) send_phase(phases[i]);
    wait_points();
  endtask

  task automatic test_register_extremes();
    // zero ratios and offsets: every angle is zero, cosine saturates at +1
    write_all(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_phase(16'h0000);
    send_phase(16'h7FFF);
    wait_points();
    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_phase(16'h8000);
    send_phase(16'h7FFF);
    send_phase(16'h5555);
    wait_points();
    // quarter-turn offsets land on the zero crossings
    write_all(lkg_pkg::RATIO_X_RST, lkg_pkg::RATIO_Y_RST, lkg_pkg::RATIO_Z_RST,
              16'h4000, 16'hC000);
    send_phase(16'h0000);
    send_phase(16'h0001);
    wait_points();
    // writes past the last register must leave the settings alone
    for (int i = int'(lkg_pkg::REG_OFFSET_Y) + 1; i < (1 << $bits(cfg_index)); i++)
      write_reg(3'(i), 16'($urandom));
    send_phase(16'h3000);
    send_phase(16'hD000);
    wait_points();
  endtask

  task automatic test_random_sweep();
    for (int s = 0; s < SWEEP_SETS; s++) begin
      if (s == 0)
        write_all(lkg_pkg::RATIO_X_RST, lkg_pkg::RATIO_Y_RST, lkg_pkg::RATIO_Z_RST,
                  lkg_pkg::OFFSET_X_RST, lkg_pkg::OFFSET_Y_RST);
      else if (s == 1)
        write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      else if (s == 2)
        write_all(16'h0000, 16'h0000, 16'h0000, 16'($urandom), 16'($urandom));
      else
        write_all(pick_reg_value(), pick_reg_value(), pick_reg_value(),
                  pick_reg_value(), pick_reg_value());
      write_reg(3'($urandom_range(int'(lkg_pkg::REG_OFFSET_Y) + 1,
                                  (1 << $bits(cfg_index)) - 1)),
                16'($urandom));
      sender_idles = 1'($urandom_range(0, 1));
      receiver_idles = 1'($urandom_range(0, 1));
      for (int i = 0; i < SWEEP_ITEMS; i++) send_phase(pick_phase());
      wait_points();
    end
  endtask

  task automatic test_backpressure();
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    hold_cycles = HOLD_CYCLES;
    for (int i = 0; i < 80; i++) send_phase(pick_phase());
    // sender pauses until the pipeline has emptied
    wait_points();
    receiver_idles = 1'b1;
    for (int i = 0; i < 40; i++) send_phase(pick_phase());
    wait_points();
  endtask

  initial begin : result_sink
    int w;
    coord_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        coord_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      w = receiver_idles ? $urandom_range(0, MAX_WAIT) : 0;
      if (w > 0) begin
        coord_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      coord_ready <= 1'b1;
      @(posedge clk);
      while (!coord_valid) @(posedge clk);
    end
  end

  function automatic void compare_field(input string name, input logic [CO_BITS-1:0] exp_v,
                                        input logic [CO_BITS-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(act_v));
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    point_t p;
    if (!rst && coord_valid && coord_ready) begin
      if (expected_points.size() == 0) begin
        $error("coord transaction with no phase transaction pending");
        mismatch_count++;
      end else begin
        p = expected_points.pop_front();
        compare_field("coord_x", p.x, coord_x);
        compare_field("coord_y", p.y, coord_y);
        compare_field("coord_z", p.z, coord_z);
        n_checked++;
      end
    end
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= lkg_pkg::REG_RATIO_X;
    cfg_data <= '0;
    phase_valid <= 1'b0;
    phase_in <= '0;
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    hold_cycles = 0;
    knot_ratio_x = lkg_pkg::RATIO_X_RST;
    knot_ratio_y = lkg_pkg::RATIO_Y_RST;
    knot_ratio_z = lkg_pkg::RATIO_Z_RST;
    knot_offset_x = lkg_pkg::OFFSET_X_RST;
    knot_offset_y = lkg_pkg::OFFSET_Y_RST;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_register_extremes();
    test_random_sweep();
    test_backpressure();
    wait_points();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("run covered %0d phase samples and %0d register writes, %0d points compared",
             n_sent, n_writes, n_checked);
    $display("settings swept: reset values, all-zero, all-ones, quarter offsets and random mixes");
    if (mismatch_count == 0 && expected_points.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
